FILE: design/tafs_pkg.sv
// ----------------------------------------------------------------------------
// tafs_pkg
// shared types and constants of the three-axis frame serializer
// ----------------------------------------------------------------------------
`default_nettype none

package tafs_pkg;

  localparam int unsigned AXIS_W   = 32;
  localparam int unsigned AXES     = 3;
  localparam int unsigned PROD_W   = 42;
  localparam int unsigned Q_SHIFT  = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic signed [PROD_W-1:0] MILLI_SCALE = PROD_W'(1000);
  localparam logic [PROD_W-1:0]        Q_BIAS      = PROD_W'(65535);

  localparam logic [BYTE_W-1:0] FRAME_HEAD  = 8'hAA;
  localparam logic [BYTE_W-1:0] PAYLOAD_LEN = 8'd12;

  localparam logic             CONVERT_RST = 1'b1;
  localparam logic [BYTE_W-1:0] DEST_RST   = 8'hFF;
  localparam logic [BYTE_W-1:0] ID_RST     = 8'hF1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONVERT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ID      = 2'd2;

  // byte positions within a frame
  localparam logic [IDX_W-1:0] IDX_HEAD     = 5'd0;
  localparam logic [IDX_W-1:0] IDX_DEST     = 5'd1;
  localparam logic [IDX_W-1:0] IDX_ID       = 5'd2;
  localparam logic [IDX_W-1:0] IDX_LEN      = 5'd3;
  localparam logic [IDX_W-1:0] IDX_PAY_FIRST = 5'd4;
  localparam logic [IDX_W-1:0] IDX_PAY_LAST  = 5'd15;
  localparam logic [IDX_W-1:0] IDX_SUM      = 5'd16;
  localparam logic [IDX_W-1:0] IDX_ADD      = 5'd17;

  typedef struct packed {
    logic                                  conv;
    logic [AXES-1:0][PROD_W-1:0]           val;
  } tafs_item_t;

endpackage

`default_nettype wire

FILE: design/tafs_scale.sv
// ----------------------------------------------------------------------------
// tafs_scale
// input register and q16.16 to thousandths multiply stage
// ----------------------------------------------------------------------------
`default_nettype none

module tafs_scale (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output      logic                                  in_ready,
  input  wire logic [tafs_pkg::AXES*tafs_pkg::AXIS_W-1:0] in_data,
  input  wire logic                                  convert,
  output      logic                                  out_valid,
  input  wire logic                                  out_ready,
  output      tafs_pkg::tafs_item_t                  out_item
);
  import tafs_pkg::*;

  logic                        a_valid_r;
  logic                        a_conv_r;
  logic [AXES*AXIS_W-1:0]      a_data_r;
  logic                        b_valid_r;
  tafs_item_t                  b_item_r;
  tafs_item_t                  b_item_nxt;
  logic                        a_to_b;
  logic                        a_load;
  logic signed [PROD_W-1:0]    ext;

  assign a_to_b   = a_valid_r && (!b_valid_r || out_ready);
  assign in_ready = !a_valid_r || a_to_b;
  assign a_load   = in_valid && in_ready;

  always_comb begin
    b_item_nxt.conv = a_conv_r;
    b_item_nxt.val  = '0;
    ext             = '0;
    for (int a = 0; a < AXES; a++) begin
      ext = $signed({{(PROD_W-AXIS_W){a_data_r[a*AXIS_W+AXIS_W-1]}},
                     a_data_r[a*AXIS_W +: AXIS_W]});
      b_item_nxt.val[a] = a_conv_r ? PROD_W'(ext * MILLI_SCALE) : ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid_r <= 1'b1;
      end else if (a_to_b) begin
        a_valid_r <= 1'b0;
      end
      if (a_to_b) begin
        b_valid_r <= 1'b1;
      end else if (out_ready) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_data_r <= in_data;
      a_conv_r <= convert;
    end
    if (a_to_b) begin
      b_item_r <= b_item_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_item  = b_item_r;

endmodule

`default_nettype wire

FILE: design/tafs_serial.sv
// ----------------------------------------------------------------------------
// tafs_serial
// frame builder: byte output register with running sum and fletcher checks
// ----------------------------------------------------------------------------
`default_nettype none

module tafs_serial (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire tafs_pkg::tafs_item_t         in_item,
  input  wire logic [tafs_pkg::BYTE_W-1:0]  dest_address,
  input  wire logic [tafs_pkg::BYTE_W-1:0]  frame_id,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [tafs_pkg::BYTE_W-1:0]  out_byte,
  output      logic                         out_last
);
  import tafs_pkg::*;

  localparam int unsigned PAY_BYTES = AXES * AXIS_W / BYTE_W;

  logic               valid_r, valid_nxt;
  logic               last_r, last_nxt;
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [BYTE_W-1:0]  sum_r, sum_nxt;
  logic [BYTE_W-1:0]  add_r, add_nxt;
  logic [BYTE_W-1:0]  pay_r [PAY_BYTES];
  logic [BYTE_W-1:0]  pay_nxt [PAY_BYTES];
  logic [PROD_W-1:0]  biased;
  logic [AXIS_W-1:0]  word;
  logic               slot_free;
  logic               cont;
  logic               load;
  logic [3:0]         pidx;

  assign slot_free = !valid_r || out_ready;
  assign cont      = valid_r && !last_r;
  assign load      = slot_free && !cont && in_valid;
  assign in_ready  = slot_free && !cont;
  assign pidx      = 4'(idx_nxt - IDX_PAY_FIRST);

  // truncating divide by 65536 on load when convert is set, else low 32 bits pass
  always_comb begin
    biased = '0;
    word   = '0;
    for (int i = 0; i < PAY_BYTES; i++) pay_nxt[i] = pay_r[i];
    for (int a = 0; a < AXES; a++) begin
      biased = in_item.val[a] + (in_item.val[a][PROD_W-1] ? Q_BIAS : '0);
      word   = in_item.conv ? AXIS_W'($signed(biased) >>> Q_SHIFT)
                            : in_item.val[a][AXIS_W-1:0];
      for (int b = 0; b < AXIS_W/BYTE_W; b++) begin
        pay_nxt[a*(AXIS_W/BYTE_W)+b] = word[b*BYTE_W +: BYTE_W];
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    last_nxt  = last_r;
    byte_nxt  = byte_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    add_nxt   = add_r;
    if (slot_free) begin
      if (cont) begin
        idx_nxt = idx_r + 5'd1;
        case (idx_nxt)
          IDX_DEST: byte_nxt = dest_address;
          IDX_ID:   byte_nxt = frame_id;
          IDX_LEN:  byte_nxt = PAYLOAD_LEN;
          IDX_SUM:  byte_nxt = sum_r;
          IDX_ADD:  byte_nxt = add_r;
          default: begin
            if (idx_nxt inside {[IDX_PAY_FIRST:IDX_PAY_LAST]}) begin
              byte_nxt = pay_r[pidx];
            end else begin
              byte_nxt = '0;
            end
          end
        endcase
        if (idx_nxt < IDX_SUM) begin
          sum_nxt = sum_r + byte_nxt;
          add_nxt = add_r + sum_nxt;
        end
        last_nxt = (idx_nxt == IDX_ADD);
      end else if (load) begin
        valid_nxt = 1'b1;
        idx_nxt   = IDX_HEAD;
        byte_nxt  = FRAME_HEAD;
        sum_nxt   = FRAME_HEAD;
        add_nxt   = FRAME_HEAD;
        last_nxt  = 1'b0;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= 1'b0;
      idx_r   <= IDX_HEAD;
    end else begin
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    sum_r  <= sum_nxt;
    add_r  <= add_nxt;
    if (load) begin
      for (int i = 0; i < PAY_BYTES; i++) pay_r[i] <= pay_nxt[i];
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

FILE: design/three_axis_frame_serializer.sv
// ----------------------------------------------------------------------------
// three_axis_frame_serializer
// packs three axis values into an 18-byte checked telemetry frame
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one transfer carries x, y, z (32 bits each, x lowest in tdata)
//   out_* : one frame byte per transfer, tlast on the second check byte
//   cfg_* : convert flag, destination address and frame id, written at idle
// path: the input transfer loads the input register, then the item moves
//   to the multiply register, then the byte output register presents the
//   head byte
// flow: one byte per cycle at the output while out_tready is high; the
//   next item is taken in and scaled while a frame is still leaving,
//   so frames follow each other with no gap
// reset: synchronous, active low; clears the pipeline valids and restores
//   convert = 1, address = 0xff, id = 0xf1
// stall: a low out_tready holds the current byte; up to two items wait in
//   the input and multiply registers before in_tready drops
// ----------------------------------------------------------------------------
`default_nettype none

module three_axis_frame_serializer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // axis_x [31:0], axis_y [63:32], axis_z [95:64]
  input  wire logic [95:0]                        in_tdata,
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  // frame_byte [7:0]
  output      logic [7:0]                         out_tdata,
  output      logic                               out_tlast,
  input  wire logic                               cfg_we,
  input  wire logic [tafs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tafs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tafs_pkg::*;

  logic               convert_r;
  logic [BYTE_W-1:0]  dest_r;
  logic [BYTE_W-1:0]  id_r;
  logic               mid_valid;
  logic               mid_ready;
  tafs_item_t         mid_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      convert_r <= CONVERT_RST;
      dest_r    <= DEST_RST;
      id_r      <= ID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONVERT: convert_r <= cfg_wdata[0];
        REG_DEST:    dest_r    <= cfg_wdata;
        REG_ID:      id_r      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  tafs_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .convert   (convert_r),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_item  (mid_item)
  );

  tafs_serial u_serial (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (mid_valid),
    .in_ready     (mid_ready),
    .in_item      (mid_item),
    .dest_address (dest_r),
    .frame_id     (id_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_byte     (out_tdata),
    .out_last     (out_tlast)
  );

endmodule

`default_nettype wire

FILE: design/tafs_checker.sv
// ----------------------------------------------------------------------------
// tafs_checker
// port-level checks on frame structure of the serializer output
// ----------------------------------------------------------------------------
`default_nettype none

module tafs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);
  import tafs_pkg::*;

  logic [IDX_W-1:0] cnt_r;
  logic             xfer;

  assign xfer = out_tvalid && out_tready;

  // byte position of the next output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= IDX_HEAD;
    end else if (xfer) begin
      cnt_r <= out_tlast ? IDX_HEAD : cnt_r + 5'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && cnt_r == IDX_HEAD |-> out_tdata == FRAME_HEAD)
    else $error("frame does not start with head byte");

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && cnt_r == IDX_LEN |-> out_tdata == PAYLOAD_LEN)
    else $error("length byte wrong");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |-> out_tlast == (cnt_r == IDX_ADD))
    else $error("tlast not on byte 18 of frame");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind three_axis_frame_serializer tafs_checker u_tafs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
